// ===== sv/arcp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arcp_pkg
// Shared widths, pipeline offsets and Pade coefficients of the arccos unit.
// ----------------------------------------------------------------------------
package arcp_pkg;

    localparam int FRAC_BITS = 30;                 // I/O fraction bits
    localparam int IFB       = 48;                 // internal fraction bits
    localparam int SHIFT_IN  = IFB - FRAC_BITS;
    localparam int VAL_W     = 58;                 // internal signed value width
    localparam int MUL_A_W   = 50;                 // narrow multiplier operand
    localparam int ANG_W     = 50;                 // clamped angle, 0..pi

    // pipeline offsets, counted from the input register
    localparam int MUL_LAT   = 4;
    localparam int STEP_LAT  = MUL_LAT + 1;        // multiply, then add coefficient
    localparam int H_STEPS   = 6;
    localparam int X2_TAPS   = H_STEPS * STEP_LAT;
    localparam int OFS_PQ    = MUL_LAT + X2_TAPS;
    localparam int OFS_DIV   = OFS_PQ + MUL_LAT;
    localparam int DIV_QBITS = 57;
    localparam int DIV_LAT   = DIV_QBITS + 3;
    localparam int OFS_XR    = OFS_DIV + DIV_LAT;
    localparam int OFS_T     = OFS_XR + MUL_LAT;
    localparam int OUT_OFS   = OFS_T + 3;

    localparam logic [127:0] TEN18 = 128'd1000000000000000000;

    // round a coefficient scaled by 2^49 to the nearest Q.48 value
    function automatic logic signed [VAL_W-1:0] coef_round(input logic [127:0] w,
                                                           input logic neg);
        logic [127:0] m;
        m = (w >> 1) + (w & 128'd1);
        return neg ? -VAL_W'(m) : VAL_W'(m);
    endfunction

    localparam logic signed [VAL_W-1:0] C_P [0:6] = '{
        coef_round((128'd166666666666666667 << 49) / TEN18, 1'b0),
        coef_round((128'd451834677893154506 << 49) / TEN18, 1'b1),
        coef_round((128'd452683382858399539 << 49) / TEN18, 1'b0),
        coef_round((128'd204511700745869575 << 49) / TEN18, 1'b1),
        coef_round((128'd40161699156136797 << 49) / TEN18, 1'b0),
        coef_round((128'd2604361227231504 << 49) / TEN18, 1'b1),
        coef_round((128'd8529836515897 << 49) / TEN18, 1'b0)
    };

    localparam logic signed [VAL_W-1:0] C_Q [0:6] = '{
        coef_round((128'd1000000000000000000 << 49) / TEN18, 1'b0),
        coef_round((128'd3161008067358927034 << 49) / TEN18, 1'b1),
        coef_round((128'd3870696784604771541 << 49) / TEN18, 1'b0),
        coef_round((128'd2304476834742890138 << 49) / TEN18, 1'b1),
        coef_round((128'd683183463380740736 << 49) / TEN18, 1'b0),
        coef_round((128'd91189047491786683 << 49) / TEN18, 1'b1),
        coef_round((128'd3926844788854131 << 49) / TEN18, 1'b0)
    };

    localparam logic signed [VAL_W:0] HALF_PI =
        (VAL_W+1)'(coef_round((128'd1570796326794896619 << 49) / TEN18, 1'b0));
    localparam logic signed [VAL_W:0] PI = HALF_PI * 2;

    localparam logic [DIV_QBITS-1:0] R_LIMIT = DIV_QBITS'(1) << 56;
    localparam logic [ANG_W:0] ROUND_OUT = (ANG_W+1)'(1) << (SHIFT_IN - 1);
    localparam logic [31:0] PI_OUT = 32'(((ANG_W+1)'(PI) + ROUND_OUT) >> SHIFT_IN);
    localparam logic signed [31:0] X_ONE = 32'sd1 <<< FRAC_BITS;

endpackage

// ===== sv/arcp_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arcp_mul
// Four-stage signed Q.48 multiplier, rounds half away from zero.
// ----------------------------------------------------------------------------
module arcp_mul
(
    input  logic                                 clk,
    input  logic signed [arcp_pkg::MUL_A_W-1:0]  a,
    input  logic signed [arcp_pkg::VAL_W-1:0]    b,
    output logic signed [arcp_pkg::VAL_W-1:0]    p
);

    logic [arcp_pkg::MUL_A_W-1:0] a_abs_w;
    logic [arcp_pkg::VAL_W-1:0]   b_abs_w;
    logic [48:0]  a_mag_reg;
    logic [56:0]  b_mag_reg;
    logic         neg0_reg;
    logic [63:0]  pp_ll_reg;
    logic [56:0]  pp_lh_reg;
    logic [48:0]  pp_hl_reg;
    logic [41:0]  pp_hh_reg;
    logic         neg1_reg;
    logic [105:0] sum_w;
    logic [56:0]  mag_reg;
    logic         neg2_reg;
    logic signed [arcp_pkg::VAL_W-1:0] p_reg;

    assign a_abs_w = a[arcp_pkg::MUL_A_W-1] ? -a : a;
    assign b_abs_w = b[arcp_pkg::VAL_W-1] ? -b : b;

    // 49 x 57 magnitude, operands split at bit 32 into four partial products
    assign sum_w = 106'(pp_ll_reg) + (106'(pp_lh_reg) << 32) + (106'(pp_hl_reg) << 32)
                 + (106'(pp_hh_reg) << 64) + (106'(1) << (arcp_pkg::IFB - 1));

    always_ff @(posedge clk)
    begin
        a_mag_reg <= a_abs_w[48:0];
        b_mag_reg <= b_abs_w[56:0];
        neg0_reg  <= a[arcp_pkg::MUL_A_W-1] ^ b[arcp_pkg::VAL_W-1];
        pp_ll_reg <= a_mag_reg[31:0] * b_mag_reg[31:0];
        pp_lh_reg <= a_mag_reg[31:0] * b_mag_reg[56:32];
        pp_hl_reg <= a_mag_reg[48:32] * b_mag_reg[31:0];
        pp_hh_reg <= a_mag_reg[48:32] * b_mag_reg[56:32];
        neg1_reg  <= neg0_reg;
        mag_reg   <= sum_w[104:48];
        neg2_reg  <= neg1_reg;
        p_reg     <= neg2_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});
    end

    assign p = p_reg;

endmodule

// ===== sv/arcp_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arcp_div
// Pipelined restoring divider, one quotient bit per stage, r = n/d in Q.48,
// truncated toward zero and saturated to +-256.
// ----------------------------------------------------------------------------
module arcp_div
(
    input  logic                               clk,
    input  logic signed [arcp_pkg::VAL_W-1:0]  num,
    input  logic signed [arcp_pkg::VAL_W-1:0]  den,
    output logic signed [arcp_pkg::VAL_W-1:0]  quo
);

    localparam int QB = arcp_pkg::DIV_QBITS;

    typedef struct packed {
        logic neg;
        logic num_neg;
        logic den_zero;
        logic over;
    } div_ctl_t;

    logic [arcp_pkg::VAL_W-1:0] n_abs_w;
    logic [arcp_pkg::VAL_W-1:0] d_abs_w;
    logic [QB-1:0]  n_mag_reg;
    logic [QB-1:0]  d_mag_reg;
    div_ctl_t       ctl0_reg;

    logic [104:0]   rem_reg [0:QB];
    logic [QB-1:0]  dq_reg  [0:QB];
    logic [QB-1:0]  qt_reg  [0:QB];
    div_ctl_t       ctl_reg [0:QB];

    logic [QB-1:0]  mag_w;
    logic           sgn_w;
    logic signed [arcp_pkg::VAL_W-1:0] quo_reg;

    assign n_abs_w = num[arcp_pkg::VAL_W-1] ? -num : num;
    assign d_abs_w = den[arcp_pkg::VAL_W-1] ? -den : den;

    always_ff @(posedge clk)
    begin
        n_mag_reg         <= n_abs_w[QB-1:0];
        d_mag_reg         <= d_abs_w[QB-1:0];
        ctl0_reg.neg      <= num[arcp_pkg::VAL_W-1] ^ den[arcp_pkg::VAL_W-1];
        ctl0_reg.num_neg  <= num[arcp_pkg::VAL_W-1];
        ctl0_reg.den_zero <= (den == '0);
        // quotient >= 2^57 exactly when n >= d * 2^9
        ctl0_reg.over     <= 66'(n_abs_w[QB-1:0]) >= (66'(d_abs_w[QB-1:0]) << 9);
        rem_reg[0]        <= {n_mag_reg[56:0], 48'b0};
        dq_reg[0]         <= d_mag_reg;
        qt_reg[0]         <= '0;
        ctl_reg[0]        <= ctl0_reg;
    end

    for (genvar i = 1; i <= QB; i++)
    begin : g_stage
        localparam int K = QB - i;
        logic [113:0] sh_w;
        logic         ge_w;

        assign sh_w = 114'(dq_reg[i-1]) << K;
        assign ge_w = 114'(rem_reg[i-1]) >= sh_w;

        always_ff @(posedge clk)
        begin
            rem_reg[i] <= ge_w ? 105'(114'(rem_reg[i-1]) - sh_w) : rem_reg[i-1];
            dq_reg[i]  <= dq_reg[i-1];
            qt_reg[i]  <= {qt_reg[i-1][QB-2:0], ge_w};
            ctl_reg[i] <= ctl_reg[i-1];
        end
    end

    always_comb
    begin
        if (ctl_reg[QB].den_zero)
        begin
            mag_w = arcp_pkg::R_LIMIT;
            sgn_w = ctl_reg[QB].num_neg;
        end
        else
        begin
            sgn_w = ctl_reg[QB].neg;
            if (ctl_reg[QB].over || qt_reg[QB] > arcp_pkg::R_LIMIT)
            begin
                mag_w = arcp_pkg::R_LIMIT;
            end
            else
            begin
                mag_w = qt_reg[QB];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= sgn_w ? -$signed({1'b0, mag_w}) : $signed({1'b0, mag_w});
    end

    assign quo = quo_reg;

endmodule

// ===== sv/arccos_pade_approx_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arccos_pade_approx_unit
// acos(x) by a (12,12) Pade approximant in Q9.48 arithmetic, Q2.30 in/out.
// ----------------------------------------------------------------------------
// Pipeline: the accepting edge loads the input register, then x*x, six Horner
//   steps (multiply, then add coefficient), x2*p, the divider, x*r and three
//   output registers lead to done.
// Throughput: one transaction per cycle; busy stays low.
// Reset clears only the valid pipeline; data registers are not reset.
// ----------------------------------------------------------------------------
module arccos_pade_approx_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] x_value,
    output logic               done,
    output logic        [31:0] angle
);

    localparam int VW = arcp_pkg::VAL_W;
    localparam int AW = arcp_pkg::MUL_A_W;

    logic                          accept_w;
    logic [arcp_pkg::OUT_OFS:0]    valid_reg;
    logic signed [31:0]            xs_w;
    logic signed [AW-1:0]          xline_reg [0:arcp_pkg::OFS_T];
    logic signed [VW-1:0]          x2_w;
    logic signed [VW-1:0]          x2d_reg [1:arcp_pkg::X2_TAPS];
    logic signed [VW-1:0]          acc_p [0:arcp_pkg::H_STEPS];
    logic signed [VW-1:0]          acc_q [0:arcp_pkg::H_STEPS];
    logic signed [VW-1:0]          x2p_w;
    logic signed [VW-1:0]          qd_reg [0:arcp_pkg::MUL_LAT-1];
    logic signed [VW-1:0]          r_w;
    logic signed [VW-1:0]          xr_w;
    logic signed [VW-1:0]          t_reg;
    logic signed [VW:0]            ang_w;
    logic [arcp_pkg::ANG_W-1:0]    ang_next;
    logic [arcp_pkg::ANG_W-1:0]    ang_reg;
    logic [31:0]                   angle_reg;

    assign busy     = 1'b0;
    assign accept_w = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[arcp_pkg::OUT_OFS-1:0], accept_w};
        end
    end

    // clamp to +-1.0, then move to 48 fraction bits
    always_comb
    begin
        if (x_value > arcp_pkg::X_ONE)
        begin
            xs_w = arcp_pkg::X_ONE;
        end
        else if (x_value < -arcp_pkg::X_ONE)
        begin
            xs_w = -arcp_pkg::X_ONE;
        end
        else
        begin
            xs_w = x_value;
        end
    end

    always_ff @(posedge clk)
    begin
        xline_reg[0] <= AW'(xs_w) <<< arcp_pkg::SHIFT_IN;
        for (int i = 1; i <= arcp_pkg::OFS_T; i++)
        begin
            xline_reg[i] <= xline_reg[i-1];
        end
    end

    arcp_mul u_mul_xx
    (
        .clk (clk),
        .a   (xline_reg[0]),
        .b   (VW'(xline_reg[0])),
        .p   (x2_w)
    );

    always_ff @(posedge clk)
    begin
        x2d_reg[1] <= x2_w;
        for (int j = 2; j <= arcp_pkg::X2_TAPS; j++)
        begin
            x2d_reg[j] <= x2d_reg[j-1];
        end
    end

    assign acc_p[0] = arcp_pkg::C_P[arcp_pkg::H_STEPS];
    assign acc_q[0] = arcp_pkg::C_Q[arcp_pkg::H_STEPS];

    // Horner steps for numerator and denominator side by side
    for (genvar s = 0; s < arcp_pkg::H_STEPS; s++)
    begin : g_horner
        logic signed [VW-1:0] z_w;
        logic signed [VW-1:0] prod_p_w;
        logic signed [VW-1:0] prod_q_w;
        logic signed [VW-1:0] acc_p_reg;
        logic signed [VW-1:0] acc_q_reg;

        if (s == 0)
        begin : g_tap0
            assign z_w = x2_w;
        end
        else
        begin : g_tapn
            assign z_w = x2d_reg[s * arcp_pkg::STEP_LAT];
        end

        arcp_mul u_mul_p
        (
            .clk (clk),
            .a   (z_w[AW-1:0]),
            .b   (acc_p[s]),
            .p   (prod_p_w)
        );

        arcp_mul u_mul_q
        (
            .clk (clk),
            .a   (z_w[AW-1:0]),
            .b   (acc_q[s]),
            .p   (prod_q_w)
        );

        always_ff @(posedge clk)
        begin
            acc_p_reg <= prod_p_w + arcp_pkg::C_P[arcp_pkg::H_STEPS - 1 - s];
            acc_q_reg <= prod_q_w + arcp_pkg::C_Q[arcp_pkg::H_STEPS - 1 - s];
        end

        assign acc_p[s+1] = acc_p_reg;
        assign acc_q[s+1] = acc_q_reg;
    end

    arcp_mul u_mul_x2p
    (
        .clk (clk),
        .a   (x2d_reg[arcp_pkg::X2_TAPS][AW-1:0]),
        .b   (acc_p[arcp_pkg::H_STEPS]),
        .p   (x2p_w)
    );

    always_ff @(posedge clk)
    begin
        qd_reg[0] <= acc_q[arcp_pkg::H_STEPS];
        for (int k = 1; k < arcp_pkg::MUL_LAT; k++)
        begin
            qd_reg[k] <= qd_reg[k-1];
        end
    end

    arcp_div u_div
    (
        .clk (clk),
        .num (x2p_w),
        .den (qd_reg[arcp_pkg::MUL_LAT-1]),
        .quo (r_w)
    );

    arcp_mul u_mul_xr
    (
        .clk (clk),
        .a   (xline_reg[arcp_pkg::OFS_XR]),
        .b   (r_w),
        .p   (xr_w)
    );

    assign ang_w = arcp_pkg::HALF_PI - (VW+1)'(t_reg);

    always_comb
    begin
        if (ang_w < 0)
        begin
            ang_next = '0;
        end
        else if (ang_w > arcp_pkg::PI)
        begin
            ang_next = arcp_pkg::ANG_W'(arcp_pkg::PI);
        end
        else
        begin
            ang_next = ang_w[arcp_pkg::ANG_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg     <= VW'(xline_reg[arcp_pkg::OFS_T]) + xr_w;
        ang_reg   <= ang_next;
        angle_reg <= 32'(((arcp_pkg::ANG_W+1)'(ang_reg) + arcp_pkg::ROUND_OUT)
                         >> arcp_pkg::SHIFT_IN);
    end

    assign done  = valid_reg[arcp_pkg::OUT_OFS];
    assign angle = angle_reg;

    a_done_origin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, arcp_pkg::OUT_OFS + 1))
        else $error("result strobe without a matching transaction");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> angle <= arcp_pkg::PI_OUT)
        else $error("angle above pi");

endmodule

// ===== tb/arccos_pade_approx_unit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arccos_pade_approx_unit_checker
// Watches input and result transactions of the arccos unit, predicts each
// angle in Q15.48 fixed point and compares results in order of arrival.
// ----------------------------------------------------------------------------
module arccos_pade_approx_unit_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [31:0] x_value,
    input  logic               done,
    input  logic        [31:0] angle,
    output int                 fail_count,
    output int                 pending
);

    localparam longint R_SAT      = longint'(1) << 56;
    localparam longint FIVE_POW18 = 64'd3814697265625;

    // coefficients times 10^18: numerator, denominator, then pi/2
    localparam longint COEF_E18 [0:14] = '{
        64'sd166666666666666667, -64'sd451834677893154506, 64'sd452683382858399539,
        -64'sd204511700745869575, 64'sd40161699156136797, -64'sd2604361227231504,
        64'sd8529836515897,
        64'sd1000000000000000000, -64'sd3161008067358927034, 64'sd3870696784604771541,
        -64'sd2304476834742890138, 64'sd683183463380740736, -64'sd91189047491786683,
        64'sd3926844788854131,
        64'sd1570796326794896619
    };

    logic [31:0] angle_q[$];

    function automatic logic [63:0] mag64(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint signed_sat(input logic [127:0] m, input logic neg);
        logic [63:0] s;
        s = (m > 128'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : m[63:0];
        return neg ? -longint'(s) : longint'(s);
    endfunction

    function automatic longint coef_fx(input int k);
        logic [127:0] qd;
        qd = ({64'd0, mag64(COEF_E18[k])} << 31) / FIVE_POW18;
        return signed_sat((qd >> 1) + (qd & 128'd1), COEF_E18[k] < 0);
    endfunction

    // rounded Q15.48 product, halves away from zero, saturating
    function automatic longint fx_product(input longint a, input longint b);
        logic [127:0] prod;
        prod = {64'd0, mag64(a)} * {64'd0, mag64(b)} + (128'd1 << 47);
        if (prod[127:111] != 0)
            return signed_sat(128'h7FFF_FFFF_FFFF_FFFF, (a < 0) != (b < 0));
        return signed_sat(prod >> 48, (a < 0) != (b < 0));
    endfunction

    function automatic longint ratio_sat(input longint n, input longint d);
        logic [127:0] md, quo;
        md = {64'd0, mag64(d)};
        if (md == 0)
            return (n < 0) ? -R_SAT : R_SAT;
        if (md > (128'd1 << 62))
            md = 128'd1 << 62;
        quo = ({64'd0, mag64(n)} << 48) / md;
        if (quo > 128'(R_SAT))
            quo = 128'(R_SAT);
        return signed_sat(quo, (n < 0) != (d < 0));
    endfunction

    function automatic longint poly_eval(input int base, input longint z);
        longint acc;
        acc = coef_fx(base + 6);
        for (int k = 5; k >= 0; k--)
            acc = coef_fx(base + k) + fx_product(z, acc);
        return acc;
    endfunction

    function automatic logic [31:0] acos_angle(input logic signed [31:0] xin);
        longint xs, x, x2, p, q, r, t, half_pi, pi_fx, ang;
        logic [63:0] u;
        xs = xin;
        if (xs > (longint'(1) << 30))
            xs = longint'(1) << 30;
        if (xs < -(longint'(1) << 30))
            xs = -(longint'(1) << 30);
        x  = xs * (longint'(1) << 18);
        x2 = fx_product(x, x);
        p  = poly_eval(0, x2);
        q  = poly_eval(7, x2);
        r  = ratio_sat(fx_product(x2, p), q);
        t  = x + fx_product(x, r);
        half_pi = coef_fx(14);
        pi_fx   = half_pi * 2;
        ang = half_pi - t;
        if (ang < 0)
            ang = 0;
        if (ang > pi_fx)
            ang = pi_fx;
        u = 64'(ang) + (64'd1 << 17);
        return u[49:18];
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (start && !busy)
                angle_q.push_back(acos_angle(x_value));
            if (done)
            begin
                if (angle_q.size() == 0)
                begin
                    $display("%0t: unexpected result transaction, angle=%h", $time, angle);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    logic [31:0] exp_angle;
                    exp_angle = angle_q.pop_front();
                    if (angle !== exp_angle)
                    begin
                        $display("%0t: angle mismatch, expected %h actual %h",
                                 $time, exp_angle, angle);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= angle_q.size();
        end
    end

endmodule

// ===== tb/arccos_pade_approx_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arccos_pade_approx_unit_tb
// Drives directed and random arguments into the arccos unit with random
// idle bursts; the checker predicts and compares every angle.
// ----------------------------------------------------------------------------
module arccos_pade_approx_unit_tb;

    localparam int N_RANDOM    = 1700;
    localparam int QUIET_TAIL  = 200;
    localparam int DRAIN_WAIT  = 130;
    localparam int CYCLE_LIMIT = 200000;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] x_value;
    logic               done;
    logic        [31:0] angle;
    int                 fail_count;
    int                 pending;
    int                 cycles;

    arccos_pade_approx_unit dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .x_value (x_value),
        .done    (done),
        .angle   (angle)
    );

    arccos_pade_approx_unit_checker chk
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .x_value    (x_value),
        .done       (done),
        .angle      (angle),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("[arccos_pade_approx_unit] ERROR");
                $finish;
            end
        end
    end

    // one transaction; start stays high into the next call
    task automatic send_x(input logic [31:0] v);
        start   <= 1'b1;
        x_value <= v;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic idle_burst();
        start <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
    endtask

    function automatic logic [31:0] random_x();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return 32'(signed'($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000);
        else if (sel < 8)   // near +-1, where the denominator gets small
            return $urandom_range(0, 1) ? 32'h4000_0000 - $urandom_range(0, 4096)
                                        : 32'hC000_0000 + $urandom_range(0, 4096);
        else if (sel < 9)   // tiny magnitudes
            return 32'(signed'($urandom_range(0, 8192)) - 4096);
        else
            return $urandom();
    endfunction

    logic [31:0] directed [] = '{
        32'h0000_0000, 32'h4000_0000, 32'hC000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
        32'h3FFF_FFFF, 32'hC000_0001, 32'h4000_0001, 32'hBFFF_FFFF, 32'h7FFF_FFFF,
        32'h8000_0000, 32'h2000_0000, 32'hE000_0000, 32'h3F00_0000, 32'hC100_0000,
        32'h5555_5555, 32'hAAAA_AAAA, 32'h1000_0000, 32'h3FFF_F000, 32'hC000_1000
    };

    initial
    begin
        rst_n   = 1'b0;
        start   = 1'b0;
        x_value = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_x(directed[i]);
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n < N_RANDOM - QUIET_TAIL && $urandom_range(0, 3) == 0)
                idle_burst();
            send_x(random_x());
        end
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("[arccos_pade_approx_unit] OK");
        else
            $display("[arccos_pade_approx_unit] ERROR");
        $finish;
    end

endmodule
